/* rtl/lca_pkg.sv */
`timescale 1ns / 1ps

package lca_pkg;

  // Field widths of the command, result and configuration channels.
  localparam int KIND_W     = 2;
  localparam int INDEX_W    = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 7;

  // Command kinds.
  localparam logic [KIND_W-1:0] KIND_SET     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GET     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_ROWS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_COLS = 8'd1;

  localparam logic [CFG_DATA_W-1:0] ACTIVE_RESET = 7'd10;

  // Neighbor count and the B3/S23 thresholds.
  localparam int NCNT_W = 4;
  localparam logic [NCNT_W-1:0] LIFE_BIRTH   = 4'd3;
  localparam logic [NCNT_W-1:0] LIFE_SURVIVE = 4'd2;

endpackage

/* rtl/lca_if.sv */
`timescale 1ns / 1ps

interface lca_cmd_if
  import lca_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic signed [INDEX_W-1:0] row_index;
  logic signed [INDEX_W-1:0] col_index;
  logic                      cell_in;

  modport source (output valid, kind, row_index, col_index, cell_in, input ready);
  modport sink (input valid, kind, row_index, col_index, cell_in, output ready);
endinterface

interface lca_rsp_if;
  logic valid;
  logic ready;
  logic cell_out;
  logic in_range;

  modport source (output valid, cell_out, in_range, input ready);
  modport sink (input valid, cell_out, in_range, output ready);
endinterface

interface lca_cfg_if
  import lca_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_idx;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_idx, wdata, input ready);
  modport sink (input valid, reg_idx, wdata, output ready);
endinterface

/* rtl/life_cellular_automaton_grid.sv */
`timescale 1ns / 1ps
// Channel  Dir  Handshake      Payload
// cmd_i    in   valid / ready  kind, row_index, col_index, cell_in
// rsp_o    out  valid / ready  cell_out, in_range
// cfg_i    in   valid / ready  reg_idx, wdata (always ready)
//
// Advance reads one row per cycle; each new row is written back after the read register,
// the row window and the rule register. Set and get pass a read state (skipped outside
// the active area) before the result; clear zeroes every row, one row a cycle.
// After reset the grid is zeroed before the first item.
// A finished result waits in the output register; the next item can be taken meanwhile,
// and its own result then stalls until that register is free.

module life_cellular_automaton_grid
  import lca_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lca_cmd_if.sink   cmd_i,
  lca_rsp_if.source rsp_o,
  lca_cfg_if.sink   cfg_i
);

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int RCW = ($clog2(MAX_ROWS + 1) > CFG_DATA_W) ? $clog2(MAX_ROWS + 1) : CFG_DATA_W;
  localparam int CCW = ($clog2(MAX_COLS + 1) > CFG_DATA_W) ? $clog2(MAX_COLS + 1) : CFG_DATA_W;

  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_CLR  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_ADV  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  // Configuration.
  logic [CFG_DATA_W-1:0] rows_q, cols_q;
  logic [RCW-1:0]        nr;
  logic [CCW-1:0]        nc;
  logic [MAX_COLS-1:0]   col_mask;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ACTIVE_RESET;
      cols_q <= ACTIVE_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      if (cfg_i.reg_idx == CFG_ACTIVE_ROWS) begin
        rows_q <= cfg_i.wdata;
      end else if (cfg_i.reg_idx == CFG_ACTIVE_COLS) begin
        cols_q <= cfg_i.wdata;
      end
    end
  end

  assign nr = (RCW'(rows_q) > RCW'(MAX_ROWS)) ? RCW'(MAX_ROWS) : RCW'(rows_q);
  assign nc = (CCW'(cols_q) > CCW'(MAX_COLS)) ? CCW'(MAX_COLS) : CCW'(cols_q);

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_mask
    assign col_mask[c] = CCW'(c) < nc;
  end

  // Control state.
  logic [2:0]     state_q, state_d;
  logic [RW-1:0]  sweep_q, sweep_d;
  logic [RCW-1:0] adv_k_q, adv_k_d;
  logic           issue_done_q, issue_done_d;
  logic           fv_q, fv_d;
  logic           fz_q, fz_d;
  logic [RCW-1:0] fj_q, fj_d;
  logic           win_vld_q, win_vld_d;
  logic [RW-1:0]  win_row_q, win_row_d;
  logic           wv_q, wv_d;
  logic [RW-1:0]  wrow_q, wrow_d;
  logic           rsp_valid_q, rsp_valid_d;

  // Payload registers.
  logic [KIND_W-1:0]   kind_q, kind_d;
  logic [RW-1:0]       rowa_q, rowa_d;
  logic [CW-1:0]       cola_q, cola_d;
  logic                cell_q, cell_d;
  logic                res_cell_q, res_cell_d;
  logic                res_hit_q, res_hit_d;
  logic                rsp_cell_q, rsp_cell_d;
  logic                rsp_hit_q, rsp_hit_d;
  logic [MAX_COLS-1:0] prev_q, prev_d, cur_q, cur_d, nxt_q, nxt_d;

  // Memory ports.
  logic                mem_wr_en, mem_rd_en;
  logic [RW-1:0]       mem_wr_addr, mem_rd_addr;
  logic [MAX_COLS-1:0] mem_wr_data, mem_rd_data;
  logic [MAX_COLS-1:0] rule_row;

  // Address decode of the offered command.
  logic [RCW-1:0]      row_ext;
  logic [CCW-1:0]      col_ext;
  logic                cmd_hit;
  logic                cmd_take;
  logic [MAX_COLS-1:0] bit_sel;
  logic [RCW-1:0]      fj_m1;

  assign row_ext = RCW'(cmd_i.row_index[INDEX_W-2:0]);
  assign col_ext = CCW'(cmd_i.col_index[INDEX_W-2:0]);
  assign cmd_hit = !cmd_i.row_index[INDEX_W-1] && !cmd_i.col_index[INDEX_W-1]
                && (row_ext < nr) && (col_ext < nc);

  assign cmd_i.ready = (state_q == ST_IDLE);
  assign cmd_take    = cmd_i.valid && cmd_i.ready;

  assign bit_sel = {{(MAX_COLS-1){1'b0}}, 1'b1} << cola_q;
  assign fj_m1   = fj_q - RCW'(1);

  always_comb begin
    state_d      = state_q;
    sweep_d      = sweep_q;
    adv_k_d      = adv_k_q;
    issue_done_d = issue_done_q;
    fv_d         = 1'b0;
    fz_d         = fz_q;
    fj_d         = fj_q;
    win_vld_d    = fv_q && (fj_q != '0);
    win_row_d    = fj_m1[RW-1:0];
    wv_d         = win_vld_q;
    wrow_d       = win_row_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    kind_d       = kind_q;
    rowa_d       = rowa_q;
    cola_d       = cola_q;
    cell_d       = cell_q;
    res_cell_d   = res_cell_q;
    res_hit_d    = res_hit_q;
    rsp_cell_d   = rsp_cell_q;
    rsp_hit_d    = rsp_hit_q;
    prev_d       = prev_q;
    cur_d        = cur_q;
    nxt_d        = nxt_q;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = sweep_q;
    mem_wr_data  = '0;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = row_ext[RW-1:0];

    // Window shift of the advance sweep; beyond the last active row reads as dead.
    if (fv_q) begin
      prev_d = cur_q;
      cur_d  = nxt_q;
      nxt_d  = fz_q ? '0 : mem_rd_data;
    end

    case (state_q)
      ST_INIT, ST_CLR: begin
        mem_wr_en = 1'b1;
        if (sweep_q == RW'(MAX_ROWS - 1)) begin
          sweep_d = '0;
          state_d = (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
        end else begin
          sweep_d = sweep_q + RW'(1);
        end
      end
      ST_IDLE: begin
        if (cmd_take) begin
          kind_d     = cmd_i.kind;
          rowa_d     = row_ext[RW-1:0];
          cola_d     = col_ext[CW-1:0];
          cell_d     = cmd_i.cell_in;
          res_cell_d = 1'b0;
          res_hit_d  = 1'b0;
          case (cmd_i.kind)
            KIND_SET, KIND_GET: begin
              res_hit_d = cmd_hit;
              if (cmd_hit) begin
                mem_rd_en = 1'b1;
                state_d   = ST_RD;
              end else begin
                state_d = ST_DONE;
              end
            end
            KIND_ADVANCE: begin
              adv_k_d      = '0;
              issue_done_d = 1'b0;
              prev_d       = '0;
              cur_d        = '0;
              nxt_d        = '0;
              state_d      = ST_ADV;
            end
            default: begin
              sweep_d = '0;
              state_d = ST_CLR;
            end
          endcase
        end
      end
      ST_RD: begin
        if (kind_q == KIND_SET) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = rowa_q;
          mem_wr_data = (mem_rd_data & ~bit_sel) | (cell_q ? bit_sel : '0);
        end else begin
          res_cell_d = mem_rd_data[cola_q];
        end
        state_d = ST_DONE;
      end
      ST_ADV: begin
        if (!issue_done_q) begin
          fv_d = 1'b1;
          fz_d = (adv_k_q >= nr);
          fj_d = adv_k_q;
          if (adv_k_q < nr) begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = adv_k_q[RW-1:0];
          end
          if (adv_k_q == nr) begin
            issue_done_d = 1'b1;
          end else begin
            adv_k_d = adv_k_q + RCW'(1);
          end
        end
        if (wv_q) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = wrow_q;
          mem_wr_data = rule_row;
        end
        if (issue_done_q && !fv_q && !win_vld_q && !wv_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          rsp_cell_d  = res_cell_q;
          rsp_hit_d   = res_hit_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      sweep_q      <= '0;
      adv_k_q      <= '0;
      issue_done_q <= 1'b1;
      fv_q         <= 1'b0;
      win_vld_q    <= 1'b0;
      wv_q         <= 1'b0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      sweep_q      <= sweep_d;
      adv_k_q      <= adv_k_d;
      issue_done_q <= issue_done_d;
      fv_q         <= fv_d;
      win_vld_q    <= win_vld_d;
      wv_q         <= wv_d;
      rsp_valid_q  <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fz_q       <= fz_d;
    fj_q       <= fj_d;
    win_row_q  <= win_row_d;
    wrow_q     <= wrow_d;
    kind_q     <= kind_d;
    rowa_q     <= rowa_d;
    cola_q     <= cola_d;
    cell_q     <= cell_d;
    res_cell_q <= res_cell_d;
    res_hit_q  <= res_hit_d;
    rsp_cell_q <= rsp_cell_d;
    rsp_hit_q  <= rsp_hit_d;
    prev_q     <= prev_d;
    cur_q      <= cur_d;
    nxt_q      <= nxt_d;
  end

  lca_grid_mem #(
    .DEPTH(MAX_ROWS),
    .WIDTH(MAX_COLS)
  ) u_mem (
    .clk_i    (clk_i),
    .wr_en_i  (mem_wr_en),
    .wr_addr_i(mem_wr_addr),
    .wr_data_i(mem_wr_data),
    .rd_en_i  (mem_rd_en),
    .rd_addr_i(mem_rd_addr),
    .rd_data_o(mem_rd_data)
  );

  lca_row_rule #(
    .WIDTH(MAX_COLS)
  ) u_rule (
    .clk_i (clk_i),
    .en_i  (win_vld_q),
    .prev_i(prev_q),
    .cur_i (cur_q),
    .nxt_i (nxt_q),
    .mask_i(col_mask),
    .row_o (rule_row)
  );

  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.cell_out = rsp_cell_q;
  assign rsp_o.in_range = rsp_hit_q;

endmodule

/* rtl/lca_grid_mem.sv */
`timescale 1ns / 1ps

module lca_grid_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/lca_row_rule.sv */
`timescale 1ns / 1ps

module lca_row_rule
  import lca_pkg::*;
#(
  parameter int WIDTH = 64
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] prev_i,
  input  logic [WIDTH-1:0] cur_i,
  input  logic [WIDTH-1:0] nxt_i,
  input  logic [WIDTH-1:0] mask_i,
  output logic [WIDTH-1:0] row_o
);

  // Rows padded with a dead column on each side; bit c+1 holds column c.
  logic [WIDTH+1:0] pp, cp, np;
  logic [WIDTH-1:0] new_row;
  logic [WIDTH-1:0] row_q;

  assign pp = {1'b0, prev_i & mask_i, 1'b0};
  assign cp = {1'b0, cur_i & mask_i, 1'b0};
  assign np = {1'b0, nxt_i & mask_i, 1'b0};

  for (genvar c = 0; c < WIDTH; c++) begin : g_col
    logic [NCNT_W-1:0] cnt;
    logic              lives;
    assign cnt = NCNT_W'(pp[c]) + NCNT_W'(pp[c+1]) + NCNT_W'(pp[c+2])
               + NCNT_W'(cp[c]) + NCNT_W'(cp[c+2])
               + NCNT_W'(np[c]) + NCNT_W'(np[c+1]) + NCNT_W'(np[c+2]);
    assign lives = (cnt == LIFE_BIRTH) || (cur_i[c] && (cnt == LIFE_SURVIVE));
    // Columns outside the active area keep their stored value.
    assign new_row[c] = mask_i[c] ? lives : cur_i[c];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      row_q <= new_row;
    end
  end

  assign row_o = row_q;

endmodule
